// ===== rtl/fip_pkg.sv =====
// ----------------------------------------------------------------------------
// fip_pkg
// Types and constants shared by the float integer power sequencer and its
// shared binary32 multiply/divide unit.
// ----------------------------------------------------------------------------
`default_nettype none

package fip_pkg;

    localparam logic [31:0] FP_ONE       = 32'h3F80_0000;
    localparam logic [31:0] FP_CANON_NAN = 32'h7FC0_0000;
    localparam logic [7:0]  FP_EXP_MAX   = 8'hFF;

    typedef enum logic {
        OP_MUL,
        OP_DIV
    } t_fpu_op;

    // Request from the sequencer to the arithmetic unit.
    typedef struct packed {
        logic    start;
        t_fpu_op op;
    } t_fpu_req;

    typedef enum logic [2:0] {
        FPU_IDLE,
        FPU_PRE,
        FPU_MUL,
        FPU_MULS,
        FPU_DIV,
        FPU_DIVS,
        FPU_POST,
        FPU_RND
    } t_fpu_state;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_ISSUE,
        SEQ_WAIT,
        SEQ_OUT
    } t_seq_state;

endpackage

`default_nettype wire

// ===== rtl/fip_fpu.sv =====
// ----------------------------------------------------------------------------
// fip_fpu
// Multi-cycle binary32 multiply or divide, round to nearest even, with
// subnormals and infinities. Any NaN result is the canonical quiet NaN.
// ----------------------------------------------------------------------------
`default_nettype none

module fip_fpu import fip_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_fpu_req    i_req,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    output logic             o_done,
    output logic [31:0]      o_result
);

    t_fpu_state r_state, n_state;
    t_fpu_op    r_op, n_op;
    logic              r_sign, n_sign;
    logic signed [9:0] r_ea, n_ea, r_eb, n_eb;
    logic [23:0]       r_ma, n_ma, r_mb, n_mb;
    logic [47:0]       r_prod, n_prod;
    logic [24:0]       r_rem, n_rem;
    logic [26:0]       r_q, n_q;
    logic [4:0]        r_cnt, n_cnt;
    logic [26:0]       r_s, n_s;
    logic signed [10:0] r_e, n_e;
    logic [31:0]       r_res, n_res;
    logic              r_done, n_done;

    logic a_nan, a_inf, a_zero, b_nan, b_inf, b_zero;
    logic        div_ge;
    logic [24:0] div_diff;
    logic [23:0] rnd_m;
    logic        rnd_inc;
    logic [24:0] rnd_m2;
    logic signed [10:0] rnd_ef;

    always_comb begin
        a_nan  = (i_a[30:23] == FP_EXP_MAX) && (i_a[22:0] != 23'd0);
        a_inf  = (i_a[30:23] == FP_EXP_MAX) && (i_a[22:0] == 23'd0);
        a_zero = (i_a[30:0] == 31'd0);
        b_nan  = (i_b[30:23] == FP_EXP_MAX) && (i_b[22:0] != 23'd0);
        b_inf  = (i_b[30:23] == FP_EXP_MAX) && (i_b[22:0] == 23'd0);
        b_zero = (i_b[30:0] == 31'd0);

        div_ge   = (r_rem >= {1'b0, r_mb});
        div_diff = div_ge ? (r_rem - {1'b0, r_mb}) : r_rem;

        // s[25] is the hidden bit, s[1] the guard bit and s[0] the sticky bit.
        rnd_m   = r_s[25:2];
        rnd_inc = r_s[1] & (r_s[0] | rnd_m[0]);
        rnd_m2  = {1'b0, rnd_m} + {24'd0, rnd_inc};
        if (rnd_m2[24]) begin
            rnd_ef = r_e + 11'sd1;
        end else if (rnd_m2[23]) begin
            rnd_ef = r_e;
        end else begin
            rnd_ef = 11'sd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FPU_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_op   <= n_op;
        r_sign <= n_sign;
        r_ea   <= n_ea;
        r_eb   <= n_eb;
        r_ma   <= n_ma;
        r_mb   <= n_mb;
        r_prod <= n_prod;
        r_rem  <= n_rem;
        r_q    <= n_q;
        r_cnt  <= n_cnt;
        r_s    <= n_s;
        r_e    <= n_e;
        r_res  <= n_res;
    end

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_sign  = r_sign;
        n_ea    = r_ea;
        n_eb    = r_eb;
        n_ma    = r_ma;
        n_mb    = r_mb;
        n_prod  = r_prod;
        n_rem   = r_rem;
        n_q     = r_q;
        n_cnt   = r_cnt;
        n_s     = r_s;
        n_e     = r_e;
        n_res   = r_res;
        n_done  = 1'b0;

        unique case (r_state)
            FPU_IDLE: begin
                if (i_req.start) begin
                    n_op   = i_req.op;
                    n_sign = i_a[31] ^ i_b[31];
                    n_ma   = {(i_a[30:23] != 8'd0), i_a[22:0]};
                    n_mb   = {(i_b[30:23] != 8'd0), i_b[22:0]};
                    n_ea   = (i_a[30:23] == 8'd0) ? 10'sd1 : $signed({2'b00, i_a[30:23]});
                    n_eb   = (i_b[30:23] == 8'd0) ? 10'sd1 : $signed({2'b00, i_b[30:23]});
                    n_state = FPU_PRE;
                    if (i_req.op == OP_MUL) begin
                        if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf)) begin
                            n_res = FP_CANON_NAN;
                            n_done = 1'b1;
                            n_state = FPU_IDLE;
                        end else if (a_inf || b_inf) begin
                            n_res = {i_a[31] ^ i_b[31], FP_EXP_MAX, 23'd0};
                            n_done = 1'b1;
                            n_state = FPU_IDLE;
                        end else if (a_zero || b_zero) begin
                            n_res = {i_a[31] ^ i_b[31], 31'd0};
                            n_done = 1'b1;
                            n_state = FPU_IDLE;
                        end
                    end else begin
                        if (a_nan || b_nan || (a_inf && b_inf) || (a_zero && b_zero)) begin
                            n_res = FP_CANON_NAN;
                            n_done = 1'b1;
                            n_state = FPU_IDLE;
                        end else if (a_inf || b_zero) begin
                            n_res = {i_a[31] ^ i_b[31], FP_EXP_MAX, 23'd0};
                            n_done = 1'b1;
                            n_state = FPU_IDLE;
                        end else if (a_zero || b_inf) begin
                            n_res = {i_a[31] ^ i_b[31], 31'd0};
                            n_done = 1'b1;
                            n_state = FPU_IDLE;
                        end
                    end
                end
            end
            FPU_PRE: begin
                // Subnormal operands are normalized one bit per cycle.
                if (!r_ma[23]) begin
                    n_ma = {r_ma[22:0], 1'b0};
                    n_ea = r_ea - 10'sd1;
                end
                if (!r_mb[23]) begin
                    n_mb = {r_mb[22:0], 1'b0};
                    n_eb = r_eb - 10'sd1;
                end
                if (r_ma[23] && r_mb[23]) begin
                    n_rem = {1'b0, r_ma};
                    n_q   = 27'd0;
                    n_cnt = 5'd0;
                    if (r_op == OP_MUL) begin
                        n_e = {r_ea[9], r_ea} + {r_eb[9], r_eb} - 11'sd127;
                        n_state = FPU_MUL;
                    end else begin
                        n_e = {r_ea[9], r_ea} - {r_eb[9], r_eb} + 11'sd127;
                        n_state = FPU_DIV;
                    end
                end
            end
            FPU_MUL: begin
                n_prod  = r_ma * r_mb;
                n_state = FPU_MULS;
            end
            FPU_MULS: begin
                n_s     = {r_prod[47:22], |r_prod[21:0]};
                n_state = FPU_POST;
            end
            FPU_DIV: begin
                n_q   = {r_q[25:0], div_ge};
                n_rem = {div_diff[23:0], 1'b0};
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd26) begin
                    n_state = FPU_DIVS;
                end
            end
            FPU_DIVS: begin
                if (r_q[26]) begin
                    n_s = {1'b0, r_q[26:2], r_q[1] | r_q[0] | (r_rem != 25'd0)};
                end else begin
                    n_s = {1'b0, r_q[25:1], r_q[0] | (r_rem != 25'd0)};
                    n_e = r_e - 11'sd1;
                end
                n_state = FPU_POST;
            end
            FPU_POST: begin
                if (r_s[26] || ((r_e < 11'sd1) && (r_e >= -11'sd30))) begin
                    n_s = {1'b0, r_s[26:2], r_s[1] | r_s[0]};
                    n_e = r_e + 11'sd1;
                end else if (r_e < 11'sd1) begin
                    // Far below the subnormal range only the sticky bit remains.
                    n_s = {26'd0, |r_s};
                    n_e = 11'sd1;
                end else begin
                    n_state = FPU_RND;
                end
            end
            FPU_RND: begin
                if (rnd_ef > 11'sd254) begin
                    n_res = {r_sign, FP_EXP_MAX, 23'd0};
                end else begin
                    n_res = {r_sign, rnd_ef[7:0], rnd_m2[22:0]};
                end
                n_done  = 1'b1;
                n_state = FPU_IDLE;
            end
            default: n_state = FPU_IDLE;
        endcase
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

`default_nettype wire

// ===== rtl/float_integer_power.sv =====
// ----------------------------------------------------------------------------
// float_integer_power
// Raises a binary32 base to a signed 32-bit integer power by squaring.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_ready carry i_base_bits and i_exponent.
// Output channel: o_out_valid / i_out_ready carry o_result_bits.
// One transaction is worked on at a time; o_in_ready is high only while idle.
// All 32 bits of the exponent magnitude are scanned, most significant first,
// through one shared multiply/divide unit. Per bit: a clear bit costs one
// multiply, a set bit of a positive exponent two multiplies, a set bit of a
// negative exponent a multiply and a divide. A multiply takes an extra step
// when the significand product reaches two. A subnormal operand is first
// normalized, a subnormal result is shifted right bit by bit, and a zero,
// infinite or NaN operand ends the operation early with a special result.
// The next transaction can be accepted in the cycle after the result is taken.
// The result stays on o_result_bits with o_out_valid high until the receiver
// takes it; a stall only holds the block in that state.
// Reset is synchronous and active low and returns the block to idle.
// ----------------------------------------------------------------------------
`default_nettype none

module float_integer_power import fip_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [31:0]        i_base_bits,
    input  wire logic signed [31:0] i_exponent,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [31:0]             o_result_bits
);

    t_seq_state  r_state, n_state;
    logic [31:0] r_x, n_x;
    logic [31:0] r_mag, n_mag;
    logic        r_neg, n_neg;
    logic [31:0] r_acc, n_acc;
    logic [31:0] r_tmp, n_tmp;
    logic [4:0]  r_bit, n_bit;
    logic        r_phase, n_phase;

    t_fpu_req    fpu_req;
    logic [31:0] fpu_a, fpu_b;
    logic        fpu_done;
    logic [31:0] fpu_res;
    logic        cur_set;

    fip_fpu u_fpu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (fpu_req),
        .i_a     (fpu_a),
        .i_b     (fpu_b),
        .o_done  (fpu_done),
        .o_result(fpu_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_x     <= n_x;
        r_mag   <= n_mag;
        r_neg   <= n_neg;
        r_acc   <= n_acc;
        r_tmp   <= n_tmp;
        r_bit   <= n_bit;
        r_phase <= n_phase;
    end

    always_comb begin
        cur_set = r_mag[r_bit];

        // Operand selection for the current step.
        fpu_req.op = OP_MUL;
        fpu_a      = r_acc;
        fpu_b      = r_acc;
        if (cur_set && !r_neg) begin
            fpu_a = r_phase ? r_tmp : r_x;
        end else if (cur_set && r_phase) begin
            fpu_req.op = OP_DIV;
            fpu_a      = r_tmp;
            fpu_b      = r_x;
        end
        fpu_req.start = (r_state == SEQ_ISSUE);
    end

    always_comb begin
        n_state = r_state;
        n_x     = r_x;
        n_mag   = r_mag;
        n_neg   = r_neg;
        n_acc   = r_acc;
        n_tmp   = r_tmp;
        n_bit   = r_bit;
        n_phase = r_phase;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;

        unique case (r_state)
            SEQ_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_x     = i_base_bits;
                    n_neg   = i_exponent[31];
                    n_mag   = i_exponent[31] ? (32'd0 - i_exponent) : i_exponent;
                    n_acc   = FP_ONE;
                    n_bit   = 5'd31;
                    n_phase = 1'b0;
                    n_state = SEQ_ISSUE;
                end
            end
            SEQ_ISSUE: begin
                n_state = SEQ_WAIT;
            end
            SEQ_WAIT: begin
                if (fpu_done) begin
                    if (cur_set && !r_phase) begin
                        n_tmp   = fpu_res;
                        n_phase = 1'b1;
                        n_state = SEQ_ISSUE;
                    end else begin
                        n_acc   = fpu_res;
                        n_phase = 1'b0;
                        if (r_bit == 5'd0) begin
                            n_state = SEQ_OUT;
                        end else begin
                            n_bit   = r_bit - 5'd1;
                            n_state = SEQ_ISSUE;
                        end
                    end
                end
            end
            SEQ_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = SEQ_IDLE;
                end
            end
            default: n_state = SEQ_IDLE;
        endcase
    end

    assign o_result_bits = r_acc;

    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a result is pending");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready && !o_out_valid)
        else $error("accepted transaction did not start work");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fpu_done |-> (r_state == SEQ_WAIT))
        else $error("arithmetic unit finished outside a wait");

endmodule

`default_nettype wire
